[hw/rtl/ascon_pkg.sv]
// Shared types, codes and the permutation round for the ASCON-128 AEAD engine.
// No dependencies; every other file takes names from here by scope.
package ascon_pkg;

    typedef logic [63:0] t_word;
    typedef t_word [4:0] t_state;
    typedef logic [1:0]  t_kind;
    typedef logic [3:0]  t_rnd;
    typedef logic [1:0]  t_cfg_idx;

    // Item kinds
    localparam t_kind KIND_START = 2'd0;
    localparam t_kind KIND_ASSOC = 2'd1;
    localparam t_kind KIND_MSG   = 2'd2;
    localparam t_kind KIND_FINAL = 2'd3;

    // Configuration register indexes
    localparam t_cfg_idx CFG_IV      = 2'd0;
    localparam t_cfg_idx CFG_KEY_HI  = 2'd1;
    localparam t_cfg_idx CFG_KEY_LO  = 2'd2;
    localparam t_cfg_idx CFG_DECRYPT = 2'd3;

    localparam t_word IV_RESET = 64'h80400c0600000000;

    // First round index for the short and the full permutation
    localparam t_rnd RND_FIRST_P12 = 4'd0;
    localparam t_rnd RND_FIRST_P6  = 4'd6;
    localparam t_rnd RND_LAST      = 4'd11;

    // Round constant: 0xF0, 0xE1, ... 0x4B
    function automatic t_word round_const(input t_rnd r);
        logic [3:0] hi;
        hi = 4'hF - r;
        return {56'd0, hi, r};
    endfunction

    function automatic t_word ror64(input t_word x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    // One round: constant addition, s-box layer, linear diffusion
    function automatic t_state ascon_round(input t_state s_in, input t_rnd r);
        t_state s;
        t_word  t0, t1, t2, t3, t4;
        s    = s_in;
        s[2] = s[2] ^ round_const(r);
        s[0] = s[0] ^ s[4];
        s[4] = s[4] ^ s[3];
        s[2] = s[2] ^ s[1];
        t0   = ~s[0] & s[1];
        t1   = ~s[1] & s[2];
        t2   = ~s[2] & s[3];
        t3   = ~s[3] & s[4];
        t4   = ~s[4] & s[0];
        s[0] = s[0] ^ t1;
        s[1] = s[1] ^ t2;
        s[2] = s[2] ^ t3;
        s[3] = s[3] ^ t4;
        s[4] = s[4] ^ t0;
        s[1] = s[1] ^ s[0];
        s[0] = s[0] ^ s[4];
        s[3] = s[3] ^ s[2];
        s[2] = ~s[2];
        s[0] = s[0] ^ ror64(s[0], 19) ^ ror64(s[0], 28);
        s[1] = s[1] ^ ror64(s[1], 61) ^ ror64(s[1], 39);
        s[2] = s[2] ^ ror64(s[2], 1)  ^ ror64(s[2], 6);
        s[3] = s[3] ^ ror64(s[3], 10) ^ ror64(s[3], 17);
        s[4] = s[4] ^ ror64(s[4], 7)  ^ ror64(s[4], 41);
        return s;
    endfunction

    // Controller to datapath commands
    typedef struct packed {
        logic  load;      // take the accepted item into the state
        logic  round;     // run one permutation round
        t_rnd  rnd;       // round index for the round command
        logic  key_add;   // xor the key into state words three and four
        logic  emit;      // load the result register
        logic  emit_tag;  // result carries the tag
    } t_cmd;

endpackage

[hw/rtl/ascon_if.sv]
// Valid/ready channel interfaces for input items and result items.
// Depends on ascon_pkg for the word and kind types.
interface ascon_in_if;
    logic              valid;
    logic              ready;
    ascon_pkg::t_kind  kind;
    ascon_pkg::t_word  word_a;
    ascon_pkg::t_word  word_b;

    modport source (output valid, output kind, output word_a, output word_b, input ready);
    modport sink   (input valid, input kind, input word_a, input word_b, output ready);
endinterface

interface ascon_out_if;
    logic              valid;
    logic              ready;
    ascon_pkg::t_word  out_word;
    ascon_pkg::t_word  tag_high;
    ascon_pkg::t_word  tag_low;
    logic              tag_valid;

    modport source (output valid, output out_word, output tag_high, output tag_low,
                    output tag_valid, input ready);
    modport sink   (input valid, input out_word, input tag_high, input tag_low,
                    input tag_valid, output ready);
endinterface

[hw/rtl/ascon_ctrl.sv]
// Sequencer for the ASCON engine: accepts items, counts rounds, drives the result handshake.
// Depends on ascon_pkg for kind codes and the command struct.
module ascon_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  ascon_pkg::t_kind  i_in_kind,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ascon_pkg::t_cmd   o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_KEY  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]        r_state, n_state;
    ascon_pkg::t_rnd   r_rnd, n_rnd;
    ascon_pkg::t_kind  r_kind, n_kind;
    logic              r_out_valid, n_out_valid;
    logic              w_accept;
    logic              w_out_free;
    logic              w_full_perm;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_accept    = i_in_valid && (r_state == ST_IDLE);
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign w_full_perm = (r_kind == ascon_pkg::KIND_START) || (r_kind == ascon_pkg::KIND_FINAL);

    // Next state, round counter and commands
    always_comb begin
        n_state     = r_state;
        n_rnd       = r_rnd;
        n_kind      = r_kind;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    n_kind     = i_in_kind;
                    n_state    = ST_RUN;
                    case (i_in_kind) inside
                        ascon_pkg::KIND_START, ascon_pkg::KIND_FINAL:
                            n_rnd = ascon_pkg::RND_FIRST_P12;
                        default: n_rnd = ascon_pkg::RND_FIRST_P6;
                    endcase
                end
            end
            ST_RUN: begin
                // Final word skips nothing: message words run p6 too
                o_cmd.round = 1'b1;
                o_cmd.rnd   = r_rnd;
                if (r_rnd == ascon_pkg::RND_LAST) begin
                    n_state = w_full_perm ? ST_KEY : ST_EMIT;
                end else begin
                    n_rnd = r_rnd + 4'd1;
                end
            end
            ST_KEY: begin
                o_cmd.key_add = 1'b1;
                n_state       = ST_EMIT;
            end
            ST_EMIT: begin
                // Hold until the result register is free
                if (w_out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_tag = (r_kind == ascon_pkg::KIND_FINAL);
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rnd       <= '0;
            r_kind      <= ascon_pkg::KIND_START;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rnd       <= n_rnd;
            r_kind      <= n_kind;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[hw/rtl/ascon_dp.sv]
// Datapath for the ASCON engine: configuration registers, 320-bit state, result register.
// Depends on ascon_pkg for the round function, codes and the command struct.
module ascon_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  ascon_pkg::t_cfg_idx  i_cfg_idx,
    input  ascon_pkg::t_word     i_cfg_data,
    input  ascon_pkg::t_cmd      i_cmd,
    input  ascon_pkg::t_kind     i_kind,
    input  ascon_pkg::t_word     i_word_a,
    input  ascon_pkg::t_word     i_word_b,
    output ascon_pkg::t_word     o_out_word,
    output ascon_pkg::t_word     o_tag_high,
    output ascon_pkg::t_word     o_tag_low,
    output logic                 o_tag_valid
);

    ascon_pkg::t_word   r_iv, r_key_hi, r_key_lo;
    logic               r_decrypt;
    ascon_pkg::t_state  r_s, n_s;
    logic               r_sep, n_sep;
    ascon_pkg::t_word   r_res, n_res;
    ascon_pkg::t_word   r_out_word, r_tag_high, r_tag_low;
    logic               r_tag_valid;
    ascon_pkg::t_word   w_res;
    ascon_pkg::t_word   w_ct;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv      <= ascon_pkg::IV_RESET;
            r_key_hi  <= '0;
            r_key_lo  <= '0;
            r_decrypt <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ascon_pkg::CFG_IV:      r_iv      <= i_cfg_data;
                ascon_pkg::CFG_KEY_HI:  r_key_hi  <= i_cfg_data;
                ascon_pkg::CFG_KEY_LO:  r_key_lo  <= i_cfg_data;
                ascon_pkg::CFG_DECRYPT: r_decrypt <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_res = i_word_a ^ r_s[0];
    assign w_ct  = r_decrypt ? i_word_a : w_res;

    // State update per command
    always_comb begin
        n_s   = r_s;
        n_sep = r_sep;
        n_res = r_res;
        if (i_cmd.load) begin
            case (i_kind)
                ascon_pkg::KIND_START: begin
                    n_s[0] = r_iv;
                    n_s[1] = r_key_hi;
                    n_s[2] = r_key_lo;
                    n_s[3] = i_word_a;
                    n_s[4] = i_word_b;
                    n_sep  = 1'b0;
                    n_res  = '0;
                end
                ascon_pkg::KIND_ASSOC: begin
                    n_s[0] = r_s[0] ^ i_word_a;
                    n_res  = '0;
                end
                default: begin
                    // Domain separation on the first message word only
                    if (!r_sep) begin
                        n_s[4] = r_s[4] ^ 64'd1;
                    end
                    n_sep  = 1'b1;
                    n_res  = w_res;
                    n_s[0] = w_ct;
                    if (i_kind == ascon_pkg::KIND_FINAL) begin
                        n_s[1] = r_s[1] ^ r_key_hi;
                        n_s[2] = r_s[2] ^ r_key_lo;
                    end
                end
            endcase
        end else if (i_cmd.round) begin
            n_s = ascon_pkg::ascon_round(r_s, i_cmd.rnd);
        end else if (i_cmd.key_add) begin
            n_s[3] = r_s[3] ^ r_key_hi;
            n_s[4] = r_s[4] ^ r_key_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s   <= '0;
            r_sep <= 1'b0;
        end else begin
            r_s   <= n_s;
            r_sep <= n_sep;
        end
    end

    // Result payload; valid lives in the controller
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (i_cmd.emit) begin
            r_out_word  <= r_res;
            r_tag_high  <= i_cmd.emit_tag ? r_s[3] : '0;
            r_tag_low   <= i_cmd.emit_tag ? r_s[4] : '0;
            r_tag_valid <= i_cmd.emit_tag;
        end
    end

    assign o_out_word  = r_out_word;
    assign o_tag_high  = r_tag_high;
    assign o_tag_low   = r_tag_low;
    assign o_tag_valid = r_tag_valid;

endmodule

[hw/rtl/ascon128_aead_engine.sv]
// Top level of the ASCON-128 AEAD engine: controller plus datapath.
// Depends on ascon_pkg, ascon_if, ascon_ctrl and ascon_dp.
//
//  channel   | dir | handshake          | payload
//  i_item    | in  | valid/ready        | kind, word_a, word_b
//  o_result  | out | valid/ready        | out_word, tag_high, tag_low, tag_valid
//  cfg       | in  | i_cfg_we (no wait) | i_cfg_idx, i_cfg_data
//
// One permutation round per cycle in a single shared round unit.
// Start and final items go through load, 12 rounds, key add and result load before the next
// accept; associated and message items go through load, 6 rounds and result load.
// One item is in work at a time; the next is accepted while the result register waits.
// A stalled result holds the engine in its last step until the register frees.
// Synchronous active-low reset restores register defaults and clears the state.
module ascon128_aead_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ascon_in_if.sink             i_item,
    ascon_out_if.source          o_result,
    input  logic                 i_cfg_we,
    input  ascon_pkg::t_cfg_idx  i_cfg_idx,
    input  ascon_pkg::t_word     i_cfg_data
);

    ascon_pkg::t_cmd  w_cmd;
    logic             w_in_ready;
    logic             w_out_valid;

    assign i_item.ready   = w_in_ready;
    assign o_result.valid = w_out_valid;

    // Sequencer
    ascon_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_in_kind   (i_item.kind),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_result.ready),
        .o_cmd       (w_cmd)
    );

    // State, configuration and result payload
    ascon_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .i_kind      (i_item.kind),
        .i_word_a    (i_item.word_a),
        .i_word_b    (i_item.word_b),
        .o_out_word  (o_result.out_word),
        .o_tag_high  (o_result.tag_high),
        .o_tag_low   (o_result.tag_low),
        .o_tag_valid (o_result.tag_valid)
    );

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the ASCON-128 AEAD engine: directed and random sessions.
// Depends on ascon_pkg, ascon_if and the engine RTL.
module tb;

    // Rotation amounts of the linear layer, six bits per state word, word 0 lowest
    localparam logic [29:0] ROT_FIRST  = {6'd7, 6'd10, 6'd1, 6'd61, 6'd19};
    localparam logic [29:0] ROT_SECOND = {6'd41, 6'd17, 6'd6, 6'd39, 6'd28};
    localparam int          DRAIN_CYCLES = 20;
    localparam int          PHASE_ITEMS  = 170;

    typedef struct packed {
        ascon_pkg::t_word out_word;
        ascon_pkg::t_word tag_high;
        ascon_pkg::t_word tag_low;
        logic             tag_valid;
    } t_engine_out;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    ascon_pkg::t_cfg_idx i_cfg_idx;
    ascon_pkg::t_word    i_cfg_data;

    ascon_in_if  item_if ();
    ascon_out_if result_if ();

    ascon128_aead_engine u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_if),
        .o_result   (result_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow of the engine: registers, sponge state, separation flag
    ascon_pkg::t_word  iv_reg     = ascon_pkg::IV_RESET;
    ascon_pkg::t_word  key_hi     = '0;
    ascon_pkg::t_word  key_lo     = '0;
    logic              decrypting = 1'b0;
    ascon_pkg::t_state sponge     = '0;
    logic              separated  = 1'b0;

    t_engine_out engine_out_due[$];
    int          error_count = 0;
    logic        no_gaps     = 1'b0;
    int          stall_left  = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic ascon_pkg::t_word rotr(input ascon_pkg::t_word x, input int n);
        return ascon_pkg::t_word'({x, x} >> n);
    endfunction

    // Run the last count rounds of the twelve-round permutation
    function automatic ascon_pkg::t_state apply_rounds(input ascon_pkg::t_state s_in,
                                                       input int count);
        ascon_pkg::t_state s;
        ascon_pkg::t_word  mix [5];
        s = s_in;
        for (int r = 12 - count; r < 12; r++) begin
            s[2] ^= ascon_pkg::t_word'(8'hF0 - 8'(r) * 8'h0F);
            s[0] ^= s[4];
            s[4] ^= s[3];
            s[2] ^= s[1];
            for (int i = 0; i < 5; i++)
                mix[i] = ~s[i] & s[(i + 1) % 5];
            for (int i = 0; i < 5; i++)
                s[i] ^= mix[(i + 1) % 5];
            s[1] ^= s[0];
            s[0] ^= s[4];
            s[3] ^= s[2];
            s[2] = ~s[2];
            for (int i = 0; i < 5; i++)
                s[i] ^= rotr(s[i], ROT_FIRST[6 * i +: 6]) ^ rotr(s[i], ROT_SECOND[6 * i +: 6]);
        end
        return s;
    endfunction

    // Mostly short pauses, now and then a long one
    function automatic int pause_length();
        int roll;
        if (no_gaps)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic ascon_pkg::t_word rand_word();
        int roll;
        roll = $urandom_range(0, 15);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    // Advance the shadow state by one item and queue the result it must produce
    task automatic advance_cipher(input ascon_pkg::t_kind kind, input ascon_pkg::t_word wa,
                                  input ascon_pkg::t_word wb);
        t_engine_out want;
        want = '0;
        case (kind)
            ascon_pkg::KIND_START: begin
                sponge[0] = iv_reg;
                sponge[1] = key_hi;
                sponge[2] = key_lo;
                sponge[3] = wa;
                sponge[4] = wb;
                sponge = apply_rounds(sponge, 12);
                sponge[3] ^= key_hi;
                sponge[4] ^= key_lo;
                separated = 1'b0;
            end
            ascon_pkg::KIND_ASSOC: begin
                sponge[0] ^= wa;
                sponge = apply_rounds(sponge, 6);
            end
            default: begin
                if (!separated) begin
                    sponge[4] ^= 64'd1;
                    separated = 1'b1;
                end
                want.out_word = wa ^ sponge[0];
                sponge[0] = decrypting ? wa : want.out_word;
                if (kind == ascon_pkg::KIND_MSG) begin
                    sponge = apply_rounds(sponge, 6);
                end else begin
                    sponge[1] ^= key_hi;
                    sponge[2] ^= key_lo;
                    sponge = apply_rounds(sponge, 12);
                    sponge[3] ^= key_hi;
                    sponge[4] ^= key_lo;
                    want.tag_high  = sponge[3];
                    want.tag_low   = sponge[4];
                    want.tag_valid = 1'b1;
                end
            end
        endcase
        engine_out_due.push_back(want);
    endtask

    task automatic report_mismatch(input string what, input ascon_pkg::t_word got,
                                   input ascon_pkg::t_word want);
        error_count++;
        if (error_count <= 40)
            $display("%0t: %s: got %h, want %h", $realtime, what, got, want);
    endtask

    // Present one item, hold it until the transaction completes, leave valid high
    task automatic send_item(input ascon_pkg::t_kind kind, input ascon_pkg::t_word wa,
                             input ascon_pkg::t_word wb);
        int gap;
        gap = pause_length();
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_if.valid  <= 1'b1;
        item_if.kind   <= kind;
        item_if.word_a <= wa;
        item_if.word_b <= wb;
        do @(posedge i_clk); while (!item_if.ready);
        advance_cipher(kind, wa, wb);
    endtask

    // Drop valid and let every outstanding result come back
    task automatic wait_idle();
        item_if.valid <= 1'b0;
        while (engine_out_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write all four registers on consecutive edges; engine must be idle
    task automatic set_config(input ascon_pkg::t_word iv, input ascon_pkg::t_word k_hi,
                              input ascon_pkg::t_word k_lo, input logic dec);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= ascon_pkg::CFG_IV;
        i_cfg_data <= iv;
        @(posedge i_clk);
        i_cfg_idx  <= ascon_pkg::CFG_KEY_HI;
        i_cfg_data <= k_hi;
        @(posedge i_clk);
        i_cfg_idx  <= ascon_pkg::CFG_KEY_LO;
        i_cfg_data <= k_lo;
        @(posedge i_clk);
        i_cfg_idx  <= ascon_pkg::CFG_DECRYPT;
        i_cfg_data <= {63'd0, dec};
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        iv_reg     = iv;
        key_hi     = k_hi;
        key_lo     = k_lo;
        decrypting = dec;
    endtask

    // Items before any start, from the all-zero reset state on, including items after a final
    task automatic test_before_start();
        send_item(ascon_pkg::KIND_MSG, '0, '0);
        send_item(ascon_pkg::KIND_MSG, '1, '1);
        send_item(ascon_pkg::KIND_ASSOC, '1, '0);
        send_item(ascon_pkg::KIND_FINAL, '0, '1);
        send_item(ascon_pkg::KIND_MSG, {$urandom, $urandom}, '0);
        wait_idle();
    endtask

    // All-ones IV and key registers and all-zero / all-ones data words
    task automatic test_field_extremes();
        set_config('1, '1, '1, 1'b0);
        send_item(ascon_pkg::KIND_START, '1, '1);
        send_item(ascon_pkg::KIND_ASSOC, '0, '1);
        send_item(ascon_pkg::KIND_ASSOC, '1, '0);
        send_item(ascon_pkg::KIND_MSG, '0, '1);
        send_item(ascon_pkg::KIND_MSG, '1, '0);
        send_item(ascon_pkg::KIND_FINAL, '1, '1);
        wait_idle();
    endtask

    // Decrypt with zero registers: final as first message word, items after a final,
    // associated data between message words
    task automatic test_session_corners();
        set_config('0, '0, '0, 1'b1);
        send_item(ascon_pkg::KIND_START, '0, '0);
        send_item(ascon_pkg::KIND_FINAL, '1, '0);
        send_item(ascon_pkg::KIND_MSG, rand_word(), rand_word());
        send_item(ascon_pkg::KIND_ASSOC, rand_word(), rand_word());
        send_item(ascon_pkg::KIND_FINAL, rand_word(), rand_word());
        send_item(ascon_pkg::KIND_START, rand_word(), rand_word());
        send_item(ascon_pkg::KIND_MSG, rand_word(), '0);
        send_item(ascon_pkg::KIND_ASSOC, rand_word(), '1);
        send_item(ascon_pkg::KIND_MSG, rand_word(), '0);
        send_item(ascon_pkg::KIND_FINAL, rand_word(), '1);
        wait_idle();
    endtask

    // Random sessions under several register settings, with some noise items mixed in
    task automatic test_random_traffic();
        int               sent;
        int               n_assoc;
        int               n_msg;
        ascon_pkg::t_word iv;
        ascon_pkg::t_word k_hi;
        ascon_pkg::t_word k_lo;
        for (int phase = 0; phase < 6; phase++) begin
            iv   = (phase == 0) ? ascon_pkg::IV_RESET : {$urandom, $urandom};
            k_hi = {$urandom, $urandom};
            k_lo = {$urandom, $urandom};
            if (phase == 2) begin
                iv   = '1;
                k_hi = '1;
                k_lo = '1;
            end else if (phase == 3) begin
                iv   = '0;
                k_hi = '0;
                k_lo = '0;
            end
            set_config(iv, k_hi, k_lo, phase[0]);
            no_gaps = (phase == 4);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 85) begin
                    n_assoc = $urandom_range(0, 3);
                    n_msg   = $urandom_range(0, 5);
                    send_item(ascon_pkg::KIND_START, rand_word(), rand_word());
                    repeat (n_assoc) send_item(ascon_pkg::KIND_ASSOC, rand_word(), rand_word());
                    repeat (n_msg) send_item(ascon_pkg::KIND_MSG, rand_word(), rand_word());
                    send_item(ascon_pkg::KIND_FINAL, rand_word(), rand_word());
                    sent += n_assoc + n_msg + 2;
                end else begin
                    n_msg = $urandom_range(1, 4);
                    repeat (n_msg) send_item(ascon_pkg::t_kind'($urandom_range(0, 3)),
                                             rand_word(), rand_word());
                    sent += n_msg;
                end
            end
            wait_idle();
            no_gaps = 1'b0;
        end
    endtask

    // Result sink: random backpressure, none while no_gaps is set
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            result_if.ready <= 1'b0;
        end else begin
            stall_left = pause_length();
            result_if.ready <= (stall_left == 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_engine_out want;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (engine_out_due.size() == 0) begin
                report_mismatch("unexpected result", result_if.out_word, '0);
            end else begin
                want = engine_out_due.pop_front();
                if (result_if.out_word !== want.out_word)
                    report_mismatch("out_word", result_if.out_word, want.out_word);
                if (result_if.tag_high !== want.tag_high)
                    report_mismatch("tag_high", result_if.tag_high, want.tag_high);
                if (result_if.tag_low !== want.tag_low)
                    report_mismatch("tag_low", result_if.tag_low, want.tag_low);
                if (result_if.tag_valid !== want.tag_valid)
                    report_mismatch("tag_valid", ascon_pkg::t_word'(result_if.tag_valid),
                                    ascon_pkg::t_word'(want.tag_valid));
            end
        end
    end

    initial begin
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= ascon_pkg::CFG_IV;
        i_cfg_data       <= '0;
        item_if.valid    <= 1'b0;
        item_if.kind     <= ascon_pkg::KIND_START;
        item_if.word_a   <= '0;
        item_if.word_b   <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_before_start();
        test_field_extremes();
        test_session_corners();
        test_random_traffic();

        wait_idle();
        if (engine_out_due.size() != 0)
            report_mismatch("results still expected",
                            ascon_pkg::t_word'(engine_out_due.size()), '0);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Hard stop if the engine hangs
    initial begin
        #(5_000_000);
        $display("Some tests failed");
        $finish;
    end

endmodule

[ascon128_aead_engine.f]
hw/rtl/ascon_pkg.sv
hw/rtl/ascon_if.sv
hw/rtl/ascon_ctrl.sv
hw/rtl/ascon_dp.sv
hw/rtl/ascon128_aead_engine.sv
tb/sv/tb.sv
